@@ rtl/core/wfq_pkg.sv @@
// shared types, constants and codes for the wfq finish time scheduler
`default_nettype none
package wfq_pkg;

  localparam int NUM_BANDS_DEF  = 4;
  localparam int BAND_DEPTH_DEF = 1024;
  localparam int BT_REGS        = 4;
  localparam int SLOT_W         = 96;

  localparam logic [63:0] MAP_LO_RST  = 64'd8;
  localparam logic [63:0] MAP_HI_RST  = 64'd0;
  localparam logic [12:0] MAX_PKT_RST = 13'd1024;
  localparam logic [31:0] BT_RST [BT_REGS] = '{32'd116508, 32'd12945, 32'd233017, 32'd233017};

  typedef enum logic [2:0] {
    REG_MAP_LO  = 3'd0,
    REG_MAP_HI  = 3'd1,
    REG_BT0     = 3'd2,
    REG_BT1     = 3'd3,
    REG_BT2     = 3'd4,
    REG_BT3     = 3'd5,
    REG_MAX_PKT = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ENQ    = 3'd0,
    ST_REJECT = 3'd1,
    ST_DROP   = 3'd2,
    ST_DEQ    = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [47:0] now_ns;
    logic [31:0] packet_id;
    logic [15:0] packet_size;
    logic [5:0]  dscp;
    logic        is_ipv4;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_packet_id;
    logic [1:0]  out_band;
    logic [15:0] out_size;
    logic [47:0] finish_ns;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] size;
    logic [47:0] arrival;
  } slot_t;

endpackage
`default_nettype wire

@@ rtl/core/wfq_slot_mem.sv @@
// packet slot memory, one write and one registered read port
`default_nettype none
module wfq_slot_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire  logic            clk,
  input  wire  logic            we,
  input  wire  logic [AW-1:0]   waddr,
  input  wire  wfq_pkg::slot_t  wdata,
  input  wire  logic [AW-1:0]   raddr,
  output wfq_pkg::slot_t        rdata
);
  import wfq_pkg::*;

  slot_t mem [DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ rtl/core/wfq_finish_calc.sv @@
// two stage head finish time: max(arrival, tail) plus rounded size times byte time
`default_nettype none
module wfq_finish_calc (
  input  wire  logic        clk,
  input  wire  logic [15:0] size,
  input  wire  logic [31:0] byte_time,
  input  wire  logic [47:0] arrival,
  input  wire  logic [47:0] tail,
  output logic       [47:0] fin
);
  import wfq_pkg::*;

  logic [47:0] prod_r;
  logic [47:0] start_r;
  logic [47:0] fin_r;
  logic [48:0] rnd;
  logic [48:0] sum;

  always_comb begin
    rnd = {1'b0, prod_r} + 49'h8000;
    sum = {1'b0, start_r} + 49'(rnd[48:16]);
  end

  always_ff @(posedge clk) begin
    prod_r  <= 48'(size) * 48'(byte_time);
    start_r <= (tail > arrival) ? tail : arrival;
    fin_r   <= sum[48] ? {48{1'b1}} : sum[47:0];
  end

  assign fin = fin_r;
endmodule
`default_nettype wire

@@ rtl/core/wfq_finish_time_scheduler.sv @@
// wfq finish time scheduler top level: band state, sequencer and result register
// One item is in work at a time. An enqueue passes through S_ENQ and S_OUT; when it
// forces a drop it also scans the bands, one band per cycle, to find the band with the
// most bytes, then reads that band's head slot and pops it. A dequeue skips bands that
// are not eligible one a cycle and, for each band that is eligible, passes through a
// slot read, multiply, add and compare.
// The single read port of the slot memory and the shared finish time unit make the bands
// be visited in turn. Slot contents need no clearing after reset; the block is ready at once.
`default_nettype none
module wfq_finish_time_scheduler #(
  parameter int NUM_BANDS  = wfq_pkg::NUM_BANDS_DEF,
  parameter int BAND_DEPTH = wfq_pkg::BAND_DEPTH_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              in_valid,
  output logic                    in_ready,
  input  wire  wfq_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire  logic              out_ready,
  output wfq_pkg::out_item_t      out_data,
  input  wire  logic              cfg_we,
  input  wire  logic [2:0]        cfg_index,
  input  wire  logic [63:0]       cfg_data
);
  import wfq_pkg::*;

  localparam int HW    = $clog2(BAND_DEPTH);
  localparam int CW    = $clog2(BAND_DEPTH + 1);
  localparam int NS    = NUM_BANDS * BAND_DEPTH;
  localparam int AW    = $clog2(NS);
  localparam int TW    = $clog2(NS + 1);
  localparam int BW    = 16 + CW;
  localparam int BIW   = $clog2(NUM_BANDS);

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_DROP_SCAN, S_DROP_RD, S_DROP_POP,
    S_DEQ_RD, S_DEQ_MUL, S_DEQ_WAIT, S_DEQ_CMP, S_DEQ_DONE, S_OUT
  } state_t;

  state_t          state_r;
  in_item_t        in_r;
  out_item_t       res_r;
  out_item_t       out_data_r;
  logic            out_valid_r;

  logic [63:0]     map_lo_r;
  logic [63:0]     map_hi_r;
  logic [31:0]     bt_r    [NUM_BANDS];
  logic [12:0]     max_r;

  logic [HW-1:0]   head_r  [NUM_BANDS];
  logic [CW-1:0]   count_r [NUM_BANDS];
  logic [BW-1:0]   bytes_r [NUM_BANDS];
  logic [47:0]     tail_r  [NUM_BANDS];
  logic [TW-1:0]   total_r;

  logic [BIW-1:0]  scan_r;
  logic [BIW-1:0]  pick_r;
  logic            found_r;
  logic [47:0]     best_r;
  logic [31:0]     best_id_r;
  logic [15:0]     best_size_r;
  logic [31:0]     cand_id_r;
  logic [15:0]     cand_size_r;

  logic [63:0]     e_map;
  logic [1:0]      e_raw;
  logic [BIW-1:0]  e_band;
  logic            e_full;
  logic [HW:0]     e_sum;
  logic [HW-1:0]   e_idx;
  logic [AW-1:0]   e_addr;
  logic            e_over;
  logic [BIW-1:0]  r_band;
  logic [AW-1:0]   r_addr;
  logic            last_band;
  logic            deq_elig;
  logic [47:0]     fin;
  slot_t           wslot;
  slot_t           rslot;
  logic            mem_we;

  always_comb begin
    e_map = (in_r.dscp[5] == 1'b0) ? map_lo_r : map_hi_r;
    e_raw = in_r.is_ipv4 ? e_map[{in_r.dscp[4:0], 1'b0} +: 2] : 2'd0;
    if (NUM_BANDS < 4 && 32'(e_raw) >= NUM_BANDS) begin
      e_band = BIW'(32'(e_raw) - NUM_BANDS);
    end else begin
      e_band = BIW'(e_raw);
    end
    e_full = (count_r[e_band] == CW'(BAND_DEPTH));
    e_sum  = (HW+1)'(head_r[e_band]) + (HW+1)'(count_r[e_band]);
    if (32'(e_sum) >= BAND_DEPTH) begin
      e_idx = HW'(32'(e_sum) - BAND_DEPTH);
    end else begin
      e_idx = HW'(e_sum);
    end
    e_addr = AW'(32'(e_band) * BAND_DEPTH) + AW'(e_idx);
    e_over = (32'(total_r) + 32'd1) > 32'(max_r);
    r_band = (state_r == S_DROP_RD) ? pick_r : scan_r;
    r_addr = AW'(32'(r_band) * BAND_DEPTH) + AW'(head_r[r_band]);
    last_band = (32'(scan_r) == NUM_BANDS - 1);
    deq_elig  = (count_r[scan_r] != '0) && (bt_r[scan_r] != '0);
    mem_we = (state_r == S_ENQ) && !e_full;
    wslot.id      = in_r.packet_id;
    wslot.size    = in_r.packet_size;
    wslot.arrival = in_r.now_ns;
  end

  wfq_slot_mem #(.DEPTH(NS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (e_addr),
    .wdata (wslot),
    .raddr (r_addr),
    .rdata (rslot)
  );

  wfq_finish_calc u_calc (
    .clk       (clk),
    .size      (rslot.size),
    .byte_time (bt_r[scan_r]),
    .arrival   (rslot.arrival),
    .tail      (tail_r[scan_r]),
    .fin       (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      map_lo_r    <= MAP_LO_RST;
      map_hi_r    <= MAP_HI_RST;
      max_r       <= MAX_PKT_RST;
      total_r     <= '0;
      scan_r      <= '0;
      pick_r      <= '0;
      found_r     <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        bt_r[b]    <= (b < BT_REGS) ? BT_RST[b] : 32'd0;
        head_r[b]  <= '0;
        count_r[b] <= '0;
        bytes_r[b] <= '0;
        tail_r[b]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAP_LO) begin
          map_lo_r <= cfg_data;
        end
        if (cfg_index == REG_MAP_HI) begin
          map_hi_r <= cfg_data;
        end
        if (cfg_index == REG_MAX_PKT) begin
          max_r <= cfg_data[12:0];
        end
        for (int b = 0; b < NUM_BANDS; b++) begin
          if (b < BT_REGS && cfg_index == 3'(32'(REG_BT0) + b)) begin
            bt_r[b] <= cfg_data[31:0];
          end
        end
      end

      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            scan_r  <= '0;
            found_r <= 1'b0;
            state_r <= in_data.req_type ? S_DEQ_RD : S_ENQ;
          end
        end
        S_ENQ: begin
          res_r.out_packet_id <= '0;
          res_r.out_size      <= '0;
          res_r.finish_ns     <= '0;
          res_r.out_band      <= 2'(e_band);
          if (e_full) begin
            res_r.status <= ST_REJECT;
            state_r      <= S_OUT;
          end else begin
            count_r[e_band] <= count_r[e_band] + CW'(1);
            bytes_r[e_band] <= bytes_r[e_band] + BW'(in_r.packet_size);
            total_r         <= total_r + TW'(1);
            res_r.status    <= ST_ENQ;
            state_r         <= e_over ? S_DROP_SCAN : S_OUT;
          end
        end
        S_DROP_SCAN: begin
          if (count_r[scan_r] != '0 && (!found_r || bytes_r[scan_r] > bytes_r[pick_r])) begin
            pick_r  <= scan_r;
            found_r <= 1'b1;
          end
          if (last_band) begin
            state_r <= S_DROP_RD;
          end else begin
            scan_r <= scan_r + BIW'(1);
          end
        end
        S_DROP_RD: begin
          state_r <= S_DROP_POP;
        end
        S_DROP_POP: begin
          head_r[pick_r]  <= (32'(head_r[pick_r]) == BAND_DEPTH - 1) ? '0
                             : head_r[pick_r] + HW'(1);
          count_r[pick_r] <= count_r[pick_r] - CW'(1);
          bytes_r[pick_r] <= bytes_r[pick_r] - BW'(rslot.size);
          total_r         <= total_r - TW'(1);
          res_r.status        <= ST_DROP;
          res_r.out_packet_id <= rslot.id;
          res_r.out_band      <= 2'(pick_r);
          res_r.out_size      <= rslot.size;
          res_r.finish_ns     <= '0;
          state_r             <= S_OUT;
        end
        S_DEQ_RD: begin
          if (deq_elig) begin
            state_r <= S_DEQ_MUL;
          end else if (last_band) begin
            state_r <= S_DEQ_DONE;
          end else begin
            scan_r <= scan_r + BIW'(1);
          end
        end
        S_DEQ_MUL: begin
          cand_id_r   <= rslot.id;
          cand_size_r <= rslot.size;
          state_r     <= S_DEQ_WAIT;
        end
        S_DEQ_WAIT: begin
          state_r <= S_DEQ_CMP;
        end
        S_DEQ_CMP: begin
          if (!found_r || fin < best_r) begin
            best_r      <= fin;
            pick_r      <= scan_r;
            best_id_r   <= cand_id_r;
            best_size_r <= cand_size_r;
            found_r     <= 1'b1;
          end
          if (last_band) begin
            state_r <= S_DEQ_DONE;
          end else begin
            scan_r  <= scan_r + BIW'(1);
            state_r <= S_DEQ_RD;
          end
        end
        S_DEQ_DONE: begin
          if (!found_r) begin
            res_r.status        <= ST_NONE;
            res_r.out_packet_id <= '0;
            res_r.out_band      <= '0;
            res_r.out_size      <= '0;
            res_r.finish_ns     <= '0;
          end else begin
            head_r[pick_r]  <= (32'(head_r[pick_r]) == BAND_DEPTH - 1) ? '0
                               : head_r[pick_r] + HW'(1);
            count_r[pick_r] <= count_r[pick_r] - CW'(1);
            bytes_r[pick_r] <= bytes_r[pick_r] - BW'(best_size_r);
            total_r         <= total_r - TW'(1);
            tail_r[pick_r]  <= best_r;
            res_r.status        <= ST_DEQ;
            res_r.out_packet_id <= best_id_r;
            res_r.out_band      <= 2'(pick_r);
            res_r.out_size      <= best_size_r;
            res_r.finish_ns     <= best_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_drop_has_packets: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DROP_SCAN |-> total_r != '0)
    else $error("drop scan with empty queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP_POP || (state_r == S_DEQ_DONE && found_r)) |-> count_r[pick_r] != '0)
    else $error("pop from empty band");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r[scan_r]) <= BAND_DEPTH)
    else $error("band count over depth");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted beat not taken into work");
`endif
endmodule
`default_nettype wire
